// ===== rtl/month_moon_phase_scan_top_assert.svh =====
// Assertion macros used by the checker file.
// Both sample on clk and are quiet while rst is high.
`ifndef MONTH_MOON_PHASE_SCAN_TOP_ASSERT_SVH
`define MONTH_MOON_PHASE_SCAN_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define MMPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define MMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mmps_pkg.sv =====
`default_nettype none
package mmps_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int PHASE_W = 3;
  localparam int DAY_W   = 5;
  localparam int BASE_W  = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Length class of a month, resolved to a day count once the leap bit is known.
  typedef enum logic [1:0] {
    MC_31,
    MC_30,
    MC_FEB
  } mon_class_t;

  // Item handed from the front to the back through the queue.
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    mon_class_t        cls;
    logic [BASE_W-1:0] base;   // day of year of day 1, minus one, before leap fix
    logic              late;   // month after February: takes the leap fix
  } fe_item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIV0,
    BK_DIV1,
    BK_DIV2,
    BK_DIV3,
    BK_DIV4,
    BK_DIV5,
    BK_DAY0,
    BK_DAY1,
    BK_DAY2,
    BK_RUN,
    BK_FLUSH
  } bk_state_t;

endpackage
`default_nettype wire

// ===== rtl/mmps_if.sv =====
`default_nettype none
interface mmps_in_if import mmps_pkg::*;;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;

  modport source (output valid, output year, output month, input ready);
  modport sink (input valid, input year, input month, output ready);
endinterface

interface mmps_out_if import mmps_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;
  logic [DAY_W-1:0]   start_day;
  logic               last;

  modport source (output valid, output phase, output start_day, output last, input ready);
  modport sink (input valid, input phase, input start_day, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/mmps_front.sv =====
`default_nettype none
module mmps_front import mmps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  mmps_in_if.sink       dates,
  output fe_item_t      push_item,
  output logic          push,
  input  wire logic     full
);

  logic               hold_valid;
  fe_item_t           hold_item;
  fe_item_t           cls_item;
  logic [MONTH_W-1:0] mi;
  logic               take;

  // Out-of-range months act as January.
  assign mi = (dates.month > MONTH_W'(12)) ? '0 : dates.month;

  always_comb begin
    cls_item.year = dates.year;
    cls_item.late = (mi > MONTH_W'(2));
    case (dates.month) inside
      4'd4, 4'd6, 4'd9, 4'd11: cls_item.cls = MC_30;
      4'd2:                    cls_item.cls = MC_FEB;
      default:                 cls_item.cls = MC_31;
    endcase
    unique case (mi)
      4'd2:    cls_item.base = BASE_W'(31);
      4'd3:    cls_item.base = BASE_W'(59);
      4'd4:    cls_item.base = BASE_W'(90);
      4'd5:    cls_item.base = BASE_W'(120);
      4'd6:    cls_item.base = BASE_W'(151);
      4'd7:    cls_item.base = BASE_W'(181);
      4'd8:    cls_item.base = BASE_W'(212);
      4'd9:    cls_item.base = BASE_W'(242);
      4'd10:   cls_item.base = BASE_W'(273);
      4'd11:   cls_item.base = BASE_W'(304);
      4'd12:   cls_item.base = BASE_W'(334);
      default: cls_item.base = '0;
    endcase
  end

  assign dates.ready = !hold_valid || !full;
  assign take        = dates.valid && dates.ready;
  assign push        = hold_valid && !full;
  assign push_item   = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= take || (hold_valid && full);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_item <= cls_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mmps_queue.sv =====
`default_nettype none
module mmps_queue import mmps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire fe_item_t push_item,
  output logic          full,
  input  wire logic     pop,
  output fe_item_t      head,
  output logic          nempty
);

  fe_item_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     cnt;

  assign full   = (cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign nempty = (cnt != '0);
  assign head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (QUEUE_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mmps_back.sv =====
`default_nettype none
module mmps_back import mmps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire fe_item_t head,
  input  wire logic     nempty,
  output logic          pop,
  mmps_out_if.source    phases
);

  bk_state_t st, st_next;

  // Year terms
  logic [7:0]  q100_0;
  logic [9:0]  q19_0;
  logic [7:0]  cent;
  logic [4:0]  golden;
  logic        leap;
  logic [5:0]  q25_0;
  logic [8:0]  x;
  logic [4:0]  q30_0;
  logic [4:0]  ep;
  logic [4:0]  len;
  logic        fix;
  logic [11:0] v;
  logic [4:0]  q177_0;

  // Day walk
  logic [7:0]         rem;
  logic [DAY_W-1:0]   day;
  logic [PHASE_W-1:0] pend_phase;
  logic [DAY_W-1:0]   pend_day;

  // Output register
  logic               out_valid;
  logic [PHASE_W-1:0] out_phase;
  logic [DAY_W-1:0]   out_day;
  logic               out_last;

  logic [21:0] prod100;
  logic [23:0] prod19;
  logic [14:0] r100;
  logic [14:0] r19;
  logic [14:0] r19c;
  logic [7:0]  q100;
  logic        y100z;
  logic [10:0] t;
  logic [16:0] prod25;
  logic [10:0] r25;
  logic [5:0]  q25;
  logic [9:0]  c34;
  logic [9:0]  x_w;
  logic [13:0] prod30;
  logic [8:0]  r30;
  logic [8:0]  e0;
  logic [4:0]  e1;
  logic [4:0]  e2;
  logic [11:0] v_w;
  logic [16:0] prod177;
  logic [11:0] r177;
  logic [8:0]  rem6;
  logic [7:0]  rem_next;
  logic [PHASE_W-1:0] ph;
  logic        first;
  logic        change;
  logic        slot_free;
  logic        run_stall;
  logic        emit_mid;
  logic        load;

  // Phase of the day from the running remainder mod 177: floor(r / 22), wrapped to 3 bits.
  function automatic logic [PHASE_W-1:0] phase_of(input logic [7:0] r);
    logic [10:0] p;
    logic [2:0]  q0;
    logic [7:0]  rr;
    logic [3:0]  q;
    p  = 11'(r) * 11'd11;
    q0 = p[10:8];
    rr = r - 8'(q0) * 8'd22;
    q  = 4'(q0) + 4'(rr >= 8'd22);
    return q[PHASE_W-1:0];
  endfunction

  // Reciprocal multiply gives a quotient at most one low; one compare fixes it.
  assign prod100 = 22'(head.year) * 22'd163;
  assign prod19  = 24'(head.year) * 24'd862;
  assign r100    = 15'(head.year) - 15'(q100_0) * 15'd100;
  assign r19     = 15'(head.year) - 15'(q19_0) * 15'd19;
  assign r19c    = (r19 >= 15'd19) ? r19 - 15'd19 : r19;
  assign q100    = q100_0 + 8'(r100 >= 15'd100);
  assign y100z   = (r100 == 15'd0) || (r100 == 15'd100);

  assign t      = {cent, 3'b000} + 11'd5;
  assign prod25 = 17'(t) * 17'd81;
  assign r25    = t - 11'(q25_0) * 11'd25;
  assign q25    = q25_0 + 6'(r25 >= 11'd25);
  assign c34    = (10'(cent) * 10'd3) >> 2;
  // Epact before mod 30, offset by 60 so it stays positive over the whole year range.
  assign x_w    = 10'(golden) * 10'd11 + 10'(q25) + 10'd87 - c34;

  assign prod30 = 14'(x) * 14'd17;
  assign r30    = x - 9'(q30_0) * 9'd30;
  assign e0     = (r30 >= 9'd30) ? r30 - 9'd30 : r30;
  assign e1     = (e0 == 9'd0) ? 5'd30 : e0[4:0];
  assign e2     = (e1 == 5'd24 || (e1 == 5'd25 && golden > 5'd11)) ? e1 + 5'd1 : e1;

  assign v_w     = (12'(head.base) + 12'(fix) + 12'(ep)) * 12'd6 + 12'd11;
  assign prod177 = 17'(v) * 17'd23;
  assign r177    = v - 12'(q177_0) * 12'd177;

  assign rem6     = 9'(rem) + 9'd6;
  assign rem_next = (rem6 >= 9'd177) ? 8'(rem6 - 9'd177) : rem6[7:0];

  assign ph        = phase_of(rem);
  assign first     = (day == DAY_W'(1));
  assign change    = first || (ph != pend_phase);
  assign slot_free = !out_valid || phases.ready;
  assign run_stall = change && !first && !slot_free;
  assign emit_mid  = (st == BK_RUN) && change && !first && slot_free;
  assign pop       = (st == BK_FLUSH) && slot_free;
  assign load      = emit_mid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      BK_IDLE:  if (nempty) st_next = BK_DIV0;
      BK_DIV0:  st_next = BK_DIV1;
      BK_DIV1:  st_next = BK_DIV2;
      BK_DIV2:  st_next = BK_DIV3;
      BK_DIV3:  st_next = BK_DIV4;
      BK_DIV4:  st_next = BK_DIV5;
      BK_DIV5:  st_next = BK_DAY0;
      BK_DAY0:  st_next = BK_DAY1;
      BK_DAY1:  st_next = BK_DAY2;
      BK_DAY2:  st_next = BK_RUN;
      BK_RUN:   if (!run_stall && day == len) st_next = BK_FLUSH;
      BK_FLUSH: if (slot_free) st_next = BK_IDLE;
      default:  st_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      BK_DIV0: begin
        q100_0 <= prod100[21:14];
        q19_0  <= prod19[23:14];
      end
      BK_DIV1: begin
        cent   <= q100 + 8'd1;
        golden <= 5'(r19c[4:0]) + 5'd1;
        leap   <= (head.year[1:0] == 2'b00) && (!y100z || q100[1:0] == 2'b00);
      end
      BK_DIV2: begin
        q25_0 <= prod25[16:11];
        fix   <= head.late && leap;
        case (head.cls)
          MC_30:   len <= 5'd30;
          MC_FEB:  len <= leap ? 5'd29 : 5'd28;
          default: len <= 5'd31;
        endcase
      end
      BK_DIV3: x     <= x_w[8:0];
      BK_DIV4: q30_0 <= prod30[13:9];
      BK_DIV5: ep    <= e2;
      BK_DAY0: v     <= v_w;
      BK_DAY1: q177_0 <= prod177[16:12];
      BK_DAY2: begin
        rem <= (r177 >= 12'd177) ? 8'(r177 - 12'd177) : r177[7:0];
        day <= DAY_W'(1);
      end
      BK_RUN: begin
        if (!run_stall) begin
          if (change) begin
            pend_phase <= ph;
            pend_day   <= day;
          end
          rem <= rem_next;
          day <= day + DAY_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (phases.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_phase <= pend_phase;
      out_day   <= pend_day;
      out_last  <= pop;
    end
  end

  assign phases.valid     = out_valid;
  assign phases.phase     = out_phase;
  assign phases.start_day = out_day;
  assign phases.last      = out_last;

endmodule
`default_nettype wire

// ===== rtl/month_moon_phase_scan_top.sv =====
// Moon phase scan over one calendar month.
//
// Channels: "dates" takes one beat per request (year, month). "phases" returns
// one beat for each day on which the moon phase (0..7) changes within that
// month, in day order; the first day always gives a beat, and the final beat
// of the month has last set. A month code outside 1..12 walks 31 days as January.
//
// Timing: the front registers and classifies a request and drops it into a
// two-deep queue. The back sequencer then works out the year terms (divides
// by 100, 19, 25 and 30 through reciprocal multiplies) and the starting
// remainder, walks the month one day per cycle while the day walk is not held
// on a phase change, and hands over the final beat in its flush state. It works
// on one month at a time; the next month starts once the flush is done. The
// first beat of a month leaves at the next phase change or at the month's end,
// as the phase of day 1 lasts one to four days.
//
// Stalls: results leave through a one-beat output register. While it is full
// and phases.ready is low, the day walk holds on a phase change; the queue and
// front keep taking requests until both are full. Reset (rst, synchronous)
// empties the queue and the output register and returns the sequencer to idle.
`default_nettype none
module month_moon_phase_scan_top import mmps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  mmps_in_if.sink    dates,
  mmps_out_if.source phases
);

  fe_item_t push_item;
  fe_item_t head;
  logic     push;
  logic     full;
  logic     pop;
  logic     nempty;

  // Accept and classify the month.
  mmps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .dates     (dates),
    .push_item (push_item),
    .push      (push),
    .full      (full)
  );

  // Decouple the front from the day walk.
  mmps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .nempty    (nempty)
  );

  // Year terms, then one day per cycle unless stalled; pop the head as the last beat is loaded.
  mmps_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .nempty (nempty),
    .pop    (pop),
    .phases (phases)
  );

endmodule
`default_nettype wire

// ===== rtl/mmps_checker.sv =====
`default_nettype none
`include "month_moon_phase_scan_top_assert.svh"
module mmps_checker import mmps_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [PHASE_W-1:0] phase,
  input wire logic [DAY_W-1:0]   start_day,
  input wire logic               last
);

  logic               mid;
  logic [PHASE_W-1:0] prev_phase;
  logic [DAY_W-1:0]   prev_day;

  // Track the last beat taken inside an unfinished month.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_phase <= phase;
      prev_day   <= start_day;
    end
  end

  `MMPS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(phase) && $stable(start_day) && $stable(last), "result changed while stalled")
  `MMPS_ASSERT_NOW(a_day_nonzero, out_valid, start_day != '0, "start day zero")
  `MMPS_ASSERT_NOW(a_day_rises, out_valid && mid, start_day > prev_day, "start day not rising within month")
  `MMPS_ASSERT_NOW(a_phase_moves, out_valid && mid, phase != prev_phase, "phase repeated within month")

endmodule

bind month_moon_phase_scan_top mmps_checker u_mmps_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (phases.valid),
  .out_ready (phases.ready),
  .phase     (phases.phase),
  .start_day (phases.start_day),
  .last      (phases.last)
);
`default_nettype wire
